@@ design/gpim_pkg.sv @@
package gpim_pkg;

	localparam int unsigned MaxPixels = 4096;
	localparam int unsigned OffW = 33;

	typedef enum logic [2:0] {
		REG_ID_START     = 3'd0,
		REG_FILL_ORDER   = 3'd1,
		REG_STEP_IN_ROW  = 3'd2,
		REG_STEP_PER_ROW = 3'd3,
		REG_X_COUNT      = 3'd4,
		REG_Y_COUNT      = 3'd5,
		REG_Z_COUNT      = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic        func;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [11:0] pos_z;
		logic signed [31:0] det_id;
	} req_t;

	typedef struct packed {
		logic signed [31:0] id_out;
		logic signed [31:0] x_out;
		logic signed [31:0] y_out;
		logic signed [31:0] z_out;
		logic        invalid;
	} rsp_t;

	// one division in flight through the cell chain
	typedef struct packed {
		logic        neg;
		logic [31:0] rem;
		logic [31:0] quo;
		logic [31:0] num;
	} div_t;

	// side data that rides alongside the divider chain
	typedef struct packed {
		logic        vld;
		logic        func;
		logic        invalid;
		logic [1:0]  fast;
		logic [1:0]  mid;
		logic [1:0]  slow;
		logic        dzero;
		logic [31:0] id;
	} tag_t;

	function automatic logic [5:0] axes(input logic [2:0] ord);
		logic [5:0] r;
		case (ord)
			3'd1: r = {2'd0, 2'd2, 2'd1};
			3'd2: r = {2'd1, 2'd0, 2'd2};
			3'd3: r = {2'd1, 2'd2, 2'd0};
			3'd4: r = {2'd2, 2'd0, 2'd1};
			3'd5: r = {2'd2, 2'd1, 2'd0};
			default: r = {2'd0, 2'd1, 2'd2};
		endcase
		return r;
	endfunction

endpackage

@@ design/gpim_div_cell.sv @@
// one restoring-division step: bring in one numerator bit, subtract if it fits
module gpim_div_cell (
	input  logic                 clk,
	input  logic                 en,
	input  logic [31:0]          dvs,
	input  gpim_pkg::div_t       d_in,
	output gpim_pkg::div_t       d_out
);
	logic [32:0] trial;
	logic [32:0] shifted;

	always_comb begin
		shifted = {d_in.rem, d_in.num[31]};
		trial   = shifted - {1'b0, dvs};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out.neg <= d_in.neg;
			d_out.num <= {d_in.num[30:0], 1'b0};
			if (!trial[32]) begin
				d_out.rem <= trial[31:0];
				d_out.quo <= {d_in.quo[30:0], 1'b1};
			end else begin
				d_out.rem <= shifted[31:0];
				d_out.quo <= {d_in.quo[30:0], 1'b0};
			end
		end
	end
endmodule

@@ design/gpim_div_chain.sv @@
// signed truncating divide by a stable divisor, one cell per quotient bit
module gpim_div_chain (
	input  logic                 clk,
	input  logic                 en,
	input  logic [31:0]          dvs,
	input  logic signed [31:0]   num,
	output logic signed [31:0]   quo,
	output logic signed [31:0]   rem
);
	gpim_pkg::div_t stg [0:32];
	logic [31:0] mag;

	always_comb begin
		mag = num[31] ? (32'd0 - num) : num;
		stg[0].neg = num[31];
		stg[0].rem = '0;
		stg[0].quo = '0;
		stg[0].num = mag;
	end

	for (genvar i = 0; i < 32; i++) begin : g_cell
		gpim_div_cell u_cell (
			.clk(clk), .en(en), .dvs(dvs), .d_in(stg[i]), .d_out(stg[i+1])
		);
	end

	assign quo = stg[32].neg ? (32'd0 - stg[32].quo) : stg[32].quo;
	assign rem = stg[32].neg ? (32'd0 - stg[32].rem) : stg[32].rem;
endmodule

@@ design/grid_pixel_id_mapper_top.sv @@
// channel | dir | handshake      | payload
// in      | in  | in_valid/stall  | gpim_pkg::req_t
// out     | out | out_valid/stall | gpim_pkg::rsp_t
// cfg     | in  | cfg_valid/ready | cfg_index, cfg_data
// one request per cycle unless a full output is stalled; data passes the input stages
// and two divider stages of 32 cells each (row quotient, then column and slow-axis divides)
// the whole pipeline advances only when the output register is free or taken,
// so out_stall holds every stage and in_stall is out_stall with a full output
// reset clears valid bits, tags and the configuration registers (x and y counts to 1) only
module grid_pixel_id_mapper_top #(
	parameter int unsigned MAX_PIXELS = gpim_pkg::MaxPixels
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  gpim_pkg::req_t   in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output gpim_pkg::rsp_t   out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_data
);
	localparam int unsigned CntW = $clog2(MAX_PIXELS + 1);
	localparam int unsigned Lat = 68;

	// configuration
	logic [31:0]     id_start_q;
	logic [2:0]      fill_order_q;
	logic [30:0]     step_in_row_q;
	logic [30:0]     step_per_row_q;
	logic [CntW-1:0] cnt_q [0:2];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_start_q     <= '0;
			fill_order_q   <= '0;
			step_in_row_q  <= '0;
			step_per_row_q <= '0;
			cnt_q[0]       <= CntW'(1);
			cnt_q[1]       <= CntW'(1);
			cnt_q[2]       <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				gpim_pkg::REG_ID_START:     id_start_q     <= cfg_data;
				gpim_pkg::REG_FILL_ORDER:   fill_order_q   <= cfg_data[2:0];
				gpim_pkg::REG_STEP_IN_ROW:  step_in_row_q  <= cfg_data[30:0];
				gpim_pkg::REG_STEP_PER_ROW: step_per_row_q <= cfg_data[30:0];
				gpim_pkg::REG_X_COUNT:      cnt_q[0]       <= CntW'(cfg_data[12:0]);
				gpim_pkg::REG_Y_COUNT:      cnt_q[1]       <= CntW'(cfg_data[12:0]);
				gpim_pkg::REG_Z_COUNT:      cnt_q[2]       <= CntW'(cfg_data[12:0]);
				default: ;
			endcase
		end
	end

	// pipeline advance: whole chain moves unless a full output is stalled
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	logic [5:0] ax;
	assign ax = gpim_pkg::axes(fill_order_q);

	// stage 1: pick axes, products of fast and mid coordinates, slow stride and offset
	gpim_pkg::tag_t tag_s1;
	logic [11:0]    cs_s1;
	logic [31:0]    pf_s1, pm_s1, sw_s1;
	logic [31:0]    off_s1;
	logic [11:0]    c [0:2];
	assign c[0] = in_data.pos_x;
	assign c[1] = in_data.pos_y;
	assign c[2] = in_data.pos_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (adv) begin
			tag_s1.vld     <= in_valid;
			tag_s1.func    <= in_data.func;
			tag_s1.invalid <= (step_in_row_q == '0) || (step_per_row_q == '0);
			tag_s1.fast    <= ax[5:4];
			tag_s1.mid     <= ax[3:2];
			tag_s1.slow    <= ax[1:0];
			tag_s1.dzero   <= (cnt_q[ax[3:2]] == '0);
			tag_s1.id      <= id_start_q;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			pf_s1  <= 32'({20'd0, c[ax[5:4]]} * {1'b0, step_in_row_q});
			pm_s1  <= 32'({20'd0, c[ax[3:2]]} * {1'b0, step_per_row_q});
			sw_s1  <= 32'(32'(cnt_q[ax[3:2]]) * {1'b0, step_per_row_q});
			cs_s1  <= c[ax[1:0]];
			off_s1 <= in_data.det_id - id_start_q;
		end
	end

	// stage 2: slow product and partial id sum
	gpim_pkg::tag_t tag_s2;
	logic [31:0] sum_s2, ps_s2, off_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tag_s2 <= '0;
		else if (adv) tag_s2 <= tag_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2 <= tag_s1.id + pf_s1 + pm_s1;
			ps_s2  <= 32'({20'd0, cs_s1} * sw_s1);
			off_s2 <= off_s1;
		end
	end

	// stage 3: forward id complete; rides along in tag
	gpim_pkg::tag_t tag_s3;
	logic [31:0] off_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
		end else if (adv) begin
			tag_s3.vld     <= tag_s2.vld;
			tag_s3.func    <= tag_s2.func;
			tag_s3.invalid <= tag_s2.invalid;
			tag_s3.fast    <= tag_s2.fast;
			tag_s3.mid     <= tag_s2.mid;
			tag_s3.slow    <= tag_s2.slow;
			tag_s3.dzero   <= tag_s2.dzero;
			tag_s3.id      <= sum_s2 + ps_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) off_s3 <= off_s2;
	end

	// first divider: off / step_per_row
	logic signed [31:0] q1, r1;
	gpim_div_chain u_div_row (
		.clk(clk), .en(adv), .dvs({1'b0, step_per_row_q}),
		.num(off_s3), .quo(q1), .rem(r1)
	);

	gpim_pkg::tag_t tag_d1 [0:32];
	assign tag_d1[0] = tag_s3;
	for (genvar i = 0; i < 32; i++) begin : g_tag1
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) tag_d1[i+1] <= '0;
			else if (adv) tag_d1[i+1] <= tag_d1[i];
		end
	end

	// second stage dividers: column = rem / step_in_row, q split by mid count
	logic signed [31:0] col, qc_r, qm_q, qm_r;
	logic [31:0] dmid;
	assign dmid = tag_d1[32].dzero ? 32'd1 : 32'(cnt_q[tag_d1[32].mid]);

	gpim_div_chain u_div_col (
		.clk(clk), .en(adv), .dvs({1'b0, step_in_row_q}),
		.num(r1), .quo(col), .rem(qc_r)
	);

	// mid divisor travels with the data since it depends on the item's order
	gpim_pkg::div_t mstg [0:32];
	logic [31:0]    mdvs [0:32];
	always_comb begin
		mstg[0].neg = q1[31];
		mstg[0].rem = '0;
		mstg[0].quo = '0;
		mstg[0].num = q1[31] ? (32'd0 - q1) : q1;
		mdvs[0]     = dmid;
	end
	for (genvar i = 0; i < 32; i++) begin : g_mid
		gpim_div_cell u_cell (
			.clk(clk), .en(adv), .dvs(mdvs[i]), .d_in(mstg[i]), .d_out(mstg[i+1])
		);
		always_ff @(posedge clk) begin
			if (adv) mdvs[i+1] <= mdvs[i];
		end
	end
	assign qm_q = mstg[32].neg ? (32'd0 - mstg[32].quo) : mstg[32].quo;
	assign qm_r = mstg[32].neg ? (32'd0 - mstg[32].rem) : mstg[32].rem;

	gpim_pkg::tag_t tag_d2 [0:32];
	assign tag_d2[0] = tag_d1[32];
	for (genvar i = 0; i < 32; i++) begin : g_tag2
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) tag_d2[i+1] <= '0;
			else if (adv) tag_d2[i+1] <= tag_d2[i];
		end
	end

	// result assembly into the output register
	gpim_pkg::tag_t t;
	logic [31:0] r [0:2];
	logic [31:0] rmid, rslow;
	gpim_pkg::rsp_t rsp;
	assign t = tag_d2[32];
	always_comb begin
		// zero mid count: whole quotient is mid, slow is zero
		rmid  = t.dzero ? qm_q : qm_r;
		rslow = t.dzero ? 32'd0 : qm_q;
		r[0] = '0;
		r[1] = '0;
		r[2] = '0;
		r[t.mid]  = rmid;
		r[t.slow] = rslow;
		r[t.fast] = col;
		rsp = '0;
		if (!t.func) begin
			rsp.id_out = t.id;
		end else if (t.invalid) begin
			rsp.x_out   = '1;
			rsp.y_out   = '1;
			rsp.z_out   = '1;
			rsp.invalid = 1'b1;
		end else begin
			rsp.x_out = r[0];
			rsp.y_out = r[1];
			rsp.z_out = r[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= t.vld;
	end
	always_ff @(posedge clk) begin
		if (adv) out_data <= rsp;
	end

	logic unused_lat;
	assign unused_lat = (Lat == 0) ^ qc_r[0];
endmodule

@@ tb/grid_pixel_id_mapper_top_test.sv @@
module grid_pixel_id_mapper_top_test;

	// pipeline depth of the design, input stages through output register
	localparam int unsigned PipeDepth = 3 + 32 + 32 + 1;
	localparam int unsigned IdleLimit = 20000;

	// register image kept by the testbench
	typedef struct {
		logic [31:0] id_start;
		logic [2:0]  fill_order;
		logic [30:0] step_in_row;
		logic [30:0] step_per_row;
		logic [12:0] cnt [3];
	} grid_cfg_t;

	// expected mapping results, oldest first
	class mapping_scoreboard;
		gpim_pkg::rsp_t pending_maps[$];
		int   errors;
		grid_cfg_t cfg;

		function new();
			errors = 0;
			cfg.id_start = '0;
			cfg.fill_order = '0;
			cfg.step_in_row = '0;
			cfg.step_per_row = '0;
			cfg.cnt[0] = 13'd1;
			cfg.cnt[1] = 13'd1;
			cfg.cnt[2] = 13'd0;
		endfunction

		function void write_reg(gpim_pkg::reg_idx_t idx, logic [31:0] v);
			case (idx)
				gpim_pkg::REG_ID_START:     cfg.id_start = v;
				gpim_pkg::REG_FILL_ORDER:   cfg.fill_order = v[2:0];
				gpim_pkg::REG_STEP_IN_ROW:  cfg.step_in_row = v[30:0];
				gpim_pkg::REG_STEP_PER_ROW: cfg.step_per_row = v[30:0];
				gpim_pkg::REG_X_COUNT:      cfg.cnt[0] = v[12:0];
				gpim_pkg::REG_Y_COUNT:      cfg.cnt[1] = v[12:0];
				gpim_pkg::REG_Z_COUNT:      cfg.cnt[2] = v[12:0];
				default: ;
			endcase
		endfunction

		// work out the mapping for one request
		function gpim_pkg::rsp_t map_request(gpim_pkg::req_t rq);
			gpim_pkg::rsp_t r;
			int fast, mid, slow;
			logic [31:0] c [3];
			logic [31:0] id;
			longint off, rs, q, d;
			longint res [3];
			r = '0;
			c[0] = {20'd0, rq.pos_x};
			c[1] = {20'd0, rq.pos_y};
			c[2] = {20'd0, rq.pos_z};
			case (cfg.fill_order)
				3'd1: begin fast = 0; mid = 2; slow = 1; end
				3'd2: begin fast = 1; mid = 0; slow = 2; end
				3'd3: begin fast = 1; mid = 2; slow = 0; end
				3'd4: begin fast = 2; mid = 0; slow = 1; end
				3'd5: begin fast = 2; mid = 1; slow = 0; end
				default: begin fast = 0; mid = 1; slow = 2; end
			endcase
			if (rq.func == 1'b0) begin
				id = cfg.id_start + c[fast] * {1'b0, cfg.step_in_row}
					+ c[mid] * {1'b0, cfg.step_per_row}
					+ c[slow] * ({19'd0, cfg.cnt[mid]} * {1'b0, cfg.step_per_row});
				r.id_out = id;
				return r;
			end
			if (cfg.step_in_row == 0 || cfg.step_per_row == 0) begin
				r.x_out = -1;
				r.y_out = -1;
				r.z_out = -1;
				r.invalid = 1'b1;
				return r;
			end
			id = rq.det_id - cfg.id_start;
			off = longint'($signed(id));
			rs = longint'(cfg.step_per_row);
			q = off / rs;
			d = longint'(cfg.cnt[mid]);
			res[fast] = (off % rs) / longint'(cfg.step_in_row);
			if (d == 0) begin
				res[mid] = q;
				res[slow] = 0;
			end else begin
				res[mid] = q % d;
				res[slow] = q / d;
			end
			r.x_out = res[0][31:0];
			r.y_out = res[1][31:0];
			r.z_out = res[2][31:0];
			return r;
		endfunction

		function void note_request(gpim_pkg::req_t rq);
			pending_maps.push_back(map_request(rq));
		endfunction

		function void check_result(gpim_pkg::rsp_t got);
			gpim_pkg::rsp_t exp_r;
			if (pending_maps.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			exp_r = pending_maps.pop_front();
			if (got.id_out !== exp_r.id_out) begin
				$display("%0t: id_out expected %h actual %h", $time, exp_r.id_out, got.id_out);
				errors++;
			end
			if (got.x_out !== exp_r.x_out) begin
				$display("%0t: x_out expected %h actual %h", $time, exp_r.x_out, got.x_out);
				errors++;
			end
			if (got.y_out !== exp_r.y_out) begin
				$display("%0t: y_out expected %h actual %h", $time, exp_r.y_out, got.y_out);
				errors++;
			end
			if (got.z_out !== exp_r.z_out) begin
				$display("%0t: z_out expected %h actual %h", $time, exp_r.z_out, got.z_out);
				errors++;
			end
			if (got.invalid !== exp_r.invalid) begin
				$display("%0t: invalid expected %b actual %b", $time, exp_r.invalid,
					got.invalid);
				errors++;
			end
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_stall;
	gpim_pkg::req_t in_data;
	logic           out_valid;
	logic           out_stall;
	gpim_pkg::rsp_t out_data;
	logic           cfg_valid;
	logic           cfg_ready;
	logic [2:0]     cfg_index;
	logic [31:0]    cfg_data;

	mapping_scoreboard sb;
	int  send_idle_pct;   // percent of cycles the request side holds back
	int  recv_stall_pct;  // percent of cycles the result side stalls
	bit  hold_off;        // forces a long output stall
	int  quiet_cycles;

	grid_pixel_id_mapper_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// result side: random stall, long hold-off on demand, check at rising edge
	always @(negedge clk) begin
		if (hold_off)
			out_stall <= 1'b1;
		else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	// watchdog on cycles with no request, result or register write accepted
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
			|| !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IdleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// write one register, waiting for the port to take it
	task automatic write_reg(gpim_pkg::reg_idx_t idx, logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		sb.write_reg(idx, v);
	endtask

	task automatic write_setup(logic [31:0] start, logic [2:0] ord, logic [30:0] sir,
		logic [30:0] spr, logic [12:0] xc, logic [12:0] yc, logic [12:0] zc);
		write_reg(gpim_pkg::REG_ID_START, start);
		write_reg(gpim_pkg::REG_FILL_ORDER, {29'd0, ord});
		write_reg(gpim_pkg::REG_STEP_IN_ROW, {1'b0, sir});
		write_reg(gpim_pkg::REG_STEP_PER_ROW, {1'b0, spr});
		write_reg(gpim_pkg::REG_X_COUNT, {19'd0, xc});
		write_reg(gpim_pkg::REG_Y_COUNT, {19'd0, yc});
		write_reg(gpim_pkg::REG_Z_COUNT, {19'd0, zc});
	endtask

	// offer one request, optionally after a random gap; valid stays up between
	// back-to-back requests
	task automatic send_request(gpim_pkg::req_t rq);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= rq;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(rq);
		@(negedge clk);
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
	endtask

	// wait until every expected result is in, then let the pipeline drain
	task automatic drain();
		end_burst();
		while (sb.pending_maps.size() != 0)
			@(negedge clk);
		repeat (PipeDepth + 8) @(negedge clk);
	endtask

	function automatic gpim_pkg::req_t make_fwd(logic [11:0] x, logic [11:0] y,
		logic [11:0] z);
		gpim_pkg::req_t r;
		r = '0;
		r.func = 1'b0;
		r.pos_x = x;
		r.pos_y = y;
		r.pos_z = z;
		r.det_id = $urandom();
		return r;
	endfunction

	function automatic gpim_pkg::req_t make_inv(logic [31:0] did);
		gpim_pkg::req_t r;
		r.func = 1'b1;
		r.pos_x = 12'($urandom());
		r.pos_y = 12'($urandom());
		r.pos_z = 12'($urandom());
		r.det_id = did;
		return r;
	endfunction

	// random request aimed at the configured grid; some ids near the wrap point
	function automatic gpim_pkg::req_t random_request();
		gpim_pkg::req_t r;
		int sel;
		sel = $urandom_range(9);
		if ($urandom_range(1) == 0) begin
			if (sel < 7)
				r = make_fwd(12'($urandom_range(63)), 12'($urandom_range(63)),
					12'($urandom_range(63)));
			else
				r = make_fwd(12'($urandom()), 12'($urandom()), 12'($urandom()));
		end else begin
			if (sel < 5)
				r = make_inv(sb.cfg.id_start + $urandom_range(100000));
			else if (sel < 7)
				r = make_inv(sb.cfg.id_start - $urandom_range(100000));
			else
				r = make_inv($urandom());
		end
		return r;
	endfunction

	// random grid setup: mostly small counts, sometimes extremes and zeros
	task automatic random_setup();
		logic [30:0] sir, spr;
		logic [12:0] cn [3];
		int k;
		sir = ($urandom_range(9) == 0) ? 31'd0 :
			($urandom_range(4) == 0) ? 31'($urandom()) : 31'($urandom_range(1, 20));
		spr = ($urandom_range(9) == 0) ? 31'd0 :
			($urandom_range(4) == 0) ? 31'($urandom()) : 31'($urandom_range(1, 400));
		for (k = 0; k < 3; k++) begin
			case ($urandom_range(7))
				0: cn[k] = 13'd4096;
				1: cn[k] = (k == 2) ? 13'd0 : 13'd1;
				default: cn[k] = 13'($urandom_range(1, 64));
			endcase
		end
		write_setup($urandom(), 3'($urandom_range(7)), sir, spr, cn[0], cn[1], cn[2]);
	endtask

	initial begin
		int i, ph;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = gpim_pkg::REG_ID_START;
		cfg_data = '0;
		hold_off = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset setup: zero steps, so inverse requests come back invalid
		send_request(make_fwd(12'd5, 12'd6, 12'd7));
		send_request(make_inv(32'h12345678));
		drain();

		// directed: extremes of every field, forward wrap, signed division
		write_setup(32'h7fff_fff0, 3'd0, 31'h7fff_ffff, 31'h7fff_ffff, 13'd4096, 13'd4096,
			13'd4096);
		send_request(make_fwd(12'hfff, 12'hfff, 12'hfff));
		send_request(make_fwd(12'h000, 12'h000, 12'h000));
		send_request(make_inv(32'h8000_0000));
		send_request(make_inv(32'h7fff_ffff));
		send_request(make_inv(32'hffff_ffff));
		drain();
		// small grid, flat (zero z count), ids below the start
		write_setup(32'h8000_0000, 3'd2, 31'd3, 31'd10, 13'd4, 13'd5, 13'd0);
		send_request(make_fwd(12'd3, 12'd4, 12'd9));
		send_request(make_inv(32'h8000_0000 + 32'd37));
		send_request(make_inv(32'h7fff_ffff));
		send_request(make_inv(32'h8000_0000 + 32'd1234));
		drain();
		// zero middle count, so the whole row quotient lands on the middle axis
		write_setup(32'd100, 3'd4, 31'd1, 31'd7, 13'd0, 13'd3, 13'd2);
		send_request(make_fwd(12'd1, 12'd2, 12'd3));
		send_request(make_inv(32'd100 + 32'd500));
		send_request(make_inv(32'd50));
		drain();
		// every fill order, including the two unused codes
		for (i = 0; i < 8; i++) begin
			write_setup(-32'sd20, 3'(i), 31'd2, 31'd9, 13'd3, 13'd4, 13'd5);
			send_request(make_fwd(12'd2, 12'd3, 12'd4));
			send_request(make_inv(32'd77));
			drain();
		end
		// zero in-row step alone flags inverse requests invalid
		write_setup(32'd0, 3'd1, 31'd0, 31'd5, 13'd2, 13'd2, 13'd2);
		send_request(make_inv(32'd9));
		drain();

		// random phases with the three idling profiles
		for (ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 52 : 0;
			recv_stall_pct = (ph == 0) ? 52 : (ph == 1) ? 29 : 0;
			for (i = 0; i < 6; i++) begin
				random_setup();
				repeat (40) send_request(random_request());
				drain();
			end
		end

		// long output hold-off while requests keep coming, so the input backs up
		send_idle_pct = 0;
		recv_stall_pct = 10;
		fork
			begin
				@(negedge clk);
				hold_off = 1'b1;
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			repeat (120) send_request(random_request());
		join
		drain();

		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
